[rtl/spa_pkg.sv]
// Shared types and constants for the sparse polynomial adder.
// Used by spa_ctrl, spa_datapath and sparse_polynomial_add.
package spa_pkg;

  // Most result terms delivered for one run
  localparam int OUT_LIMIT = 32;
  // Result counter width, holds 0..OUT_LIMIT
  localparam int RES_CNT_W = 6;
  // Width that holds the sum of both term counts
  localparam int SUM_W     = 7;

  localparam int COEFF_W   = 16;
  localparam int EXPO_W    = 16;
  localparam int SUM_C_W   = 17;

  localparam int S_DATA_W  = 40;
  localparam int M_DATA_W  = 40;
  localparam int M_USER_W  = 2;

  typedef struct packed {
    logic signed [COEFF_W-1:0] coeff;
    logic        [EXPO_W-1:0]  expo;
  } term_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PRIME,
    ST_COUNT,
    ST_MERGE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // take input beats
    logic prime;       // rewind read positions, fetch first entries
    logic count_step;  // dry merge step, count results only
    logic merge;       // merge step, emit when the output slot is free
  } spa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic close_now;   // accepted beat closes the second of the two lists
    logic need_count;  // merge may give more than OUT_LIMIT results
    logic counted;     // dry pass already done for this run
    logic count_done;  // dry pass finishes this cycle
    logic emit_last;   // final result of the run goes out this cycle
  } spa_status_t;

endpackage

[rtl/sparse_polynomial_add.sv]
// Sparse polynomial adder: loads two term lists, then merges them.
// Load: one input beat per cycle. Merge: the closing beat is followed by a prime
// state that rewinds the read positions, then the merge state loads the output register
// with one result per cycle while the output is taken. If the two lists together hold
// more than 32 terms, a dry counting pass and a second prime state come first.
// Synchronous active-high reset empties both lists.
module sparse_polynomial_add #(
  parameter int MAX_TERMS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [0] term_present, [16:1] term_coeff, [32:17] term_expo, [39:33] zero
  input  logic [spa_pkg::S_DATA_W-1:0]   s_tdata,
  // [0] req_type
  input  logic                           s_tuser,
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [16:0] sum_coeff, [32:17] result_expo, [39:33] zero
  output logic [spa_pkg::M_DATA_W-1:0]   m_tdata,
  // [0] result_empty, [1] terms_dropped
  output logic [spa_pkg::M_USER_W-1:0]   m_tuser,
  output logic                           m_tlast
);
  import spa_pkg::*;

  spa_cmd_t    cmd;
  spa_status_t st;

  assign s_tready = cmd.load;

  spa_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  spa_datapath #(
    .MAX_TERMS (MAX_TERMS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

[rtl/spa_ctrl.sv]
// Controller state machine for the sparse polynomial adder.
// Depends on spa_pkg; drives commands to spa_datapath.
module spa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  spa_pkg::spa_status_t st,
  output spa_pkg::spa_cmd_t    cmd
);
  import spa_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_LOAD: begin
        cmd.load = 1'b1;
        if (st.close_now) begin
          state_next = ST_PRIME;
        end
      end
      ST_PRIME: begin
        cmd.prime = 1'b1;
        if (st.need_count && !st.counted) begin
          state_next = ST_COUNT;
        end else begin
          state_next = ST_MERGE;
        end
      end
      ST_COUNT: begin
        cmd.count_step = 1'b1;
        if (st.count_done) begin
          state_next = ST_PRIME;
        end
      end
      ST_MERGE: begin
        cmd.merge = 1'b1;
        if (st.emit_last) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

[rtl/spa_datapath.sv]
// Datapath of the sparse polynomial adder: term stores, merge compare/add,
// result counter and output register. Depends on spa_pkg; driven by spa_ctrl.
module spa_datapath #(
  parameter int MAX_TERMS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  spa_pkg::spa_cmd_t              cmd,
  output spa_pkg::spa_status_t           st,
  input  logic                           s_tvalid,
  input  logic [spa_pkg::S_DATA_W-1:0]   s_tdata,
  input  logic                           s_tuser,
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [spa_pkg::M_DATA_W-1:0]   m_tdata,
  output logic [spa_pkg::M_USER_W-1:0]   m_tuser,
  output logic                           m_tlast
);
  import spa_pkg::*;

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  // Term stores and their registered read ports
  term_t store_a [MAX_TERMS];
  term_t store_b [MAX_TERMS];
  term_t rd_a;
  term_t rd_b;

  logic [CW-1:0]        cnt_a;
  logic [CW-1:0]        cnt_b;
  logic [CW-1:0]        pos_a;
  logic [CW-1:0]        pos_b;
  logic [CW-1:0]        pos_a_next;
  logic [CW-1:0]        pos_b_next;
  logic [CW-1:0]        pos_a_inc;
  logic [CW-1:0]        pos_b_inc;
  logic                 closed_a;
  logic                 closed_b;
  logic                 ovf;
  logic                 trunc;
  logic                 counted;
  logic [RES_CNT_W-1:0] res_n;

  // Input beat fields
  logic                      in_present;
  logic signed [COEFF_W-1:0] in_coeff;
  logic [EXPO_W-1:0]         in_expo;
  logic                      acc;
  logic                      sel_closed;
  logic                      other_closed;
  logic [CW-1:0]             sel_cnt;
  logic                      wr_en;

  // Merge step
  logic                      a_ok;
  logic                      b_ok;
  logic                      eq;
  logic                      a_gt;
  logic                      take_a;
  logic                      take_b;
  logic signed [SUM_C_W-1:0] step_coeff;
  logic [EXPO_W-1:0]         step_expo;
  logic                      exhaust_after;
  logic                      empty_run;
  logic                      slot_free;
  logic                      emit;
  logic                      adv;
  logic                      at_limit;

  assign in_present = s_tdata[0];
  assign in_coeff   = s_tdata[COEFF_W:1];
  assign in_expo    = s_tdata[COEFF_W+EXPO_W:COEFF_W+1];

  // Input handshake and list selection
  assign acc          = cmd.load && s_tvalid;
  assign sel_closed   = s_tuser ? closed_b : closed_a;
  assign other_closed = s_tuser ? closed_a : closed_b;
  assign sel_cnt      = s_tuser ? cnt_b : cnt_a;
  assign wr_en        = acc && !sel_closed && in_present && (sel_cnt < CW'(MAX_TERMS));

  // Merge compare and add
  assign a_ok = pos_a < cnt_a;
  assign b_ok = pos_b < cnt_b;
  assign eq   = rd_a.expo == rd_b.expo;
  assign a_gt = rd_a.expo > rd_b.expo;
  assign take_a = a_ok && (!b_ok || eq || a_gt);
  assign take_b = b_ok && (!a_ok || eq || !a_gt);

  always_comb begin
    if (take_a && take_b) begin
      step_coeff = SUM_C_W'(rd_a.coeff) + SUM_C_W'(rd_b.coeff);
    end else if (take_a) begin
      step_coeff = SUM_C_W'(rd_a.coeff);
    end else begin
      step_coeff = SUM_C_W'(rd_b.coeff);
    end
  end
  assign step_expo = take_a ? rd_a.expo : rd_b.expo;

  assign pos_a_inc     = pos_a + CW'(take_a);
  assign pos_b_inc     = pos_b + CW'(take_b);
  assign exhaust_after = (pos_a_inc == cnt_a) && (pos_b_inc == cnt_b);
  assign empty_run     = !a_ok && !b_ok;
  assign slot_free     = !m_tvalid || m_tready;
  assign emit          = cmd.merge && slot_free;
  assign adv           = emit || cmd.count_step;
  assign at_limit      = res_n == RES_CNT_W'(OUT_LIMIT);

  // Status to controller
  assign st.close_now  = acc && !sel_closed && s_tlast && other_closed;
  assign st.need_count = (SUM_W'(cnt_a) + SUM_W'(cnt_b)) > SUM_W'(OUT_LIMIT);
  assign st.counted    = counted;
  assign st.count_done = cmd.count_step && (at_limit || exhaust_after);
  assign st.emit_last  = emit && (exhaust_after || (res_n == RES_CNT_W'(OUT_LIMIT - 1)));

  // Read positions: rewind on prime or end of run, step with each merge or count step
  always_comb begin
    if (cmd.prime || st.emit_last) begin
      pos_a_next = '0;
      pos_b_next = '0;
    end else if (adv) begin
      pos_a_next = pos_a_inc;
      pos_b_next = pos_b_inc;
    end else begin
      pos_a_next = pos_a;
      pos_b_next = pos_b;
    end
  end

  // Control state of the run
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a    <= '0;
      cnt_b    <= '0;
      closed_a <= 1'b0;
      closed_b <= 1'b0;
      ovf      <= 1'b0;
      trunc    <= 1'b0;
      counted  <= 1'b0;
      pos_a    <= '0;
      pos_b    <= '0;
      res_n    <= '0;
    end else begin
      pos_a <= pos_a_next;
      pos_b <= pos_b_next;
      if (st.emit_last) begin
        cnt_a    <= '0;
        cnt_b    <= '0;
        closed_a <= 1'b0;
        closed_b <= 1'b0;
        ovf      <= 1'b0;
        trunc    <= 1'b0;
        counted  <= 1'b0;
        res_n    <= '0;
      end else begin
        // Load terms, flag overflow, close lists
        if (acc && !sel_closed) begin
          if (in_present) begin
            if (wr_en) begin
              if (s_tuser) begin
                cnt_b <= cnt_b + CW'(1);
              end else begin
                cnt_a <= cnt_a + CW'(1);
              end
            end else begin
              ovf <= 1'b1;
            end
          end
          if (s_tlast) begin
            if (s_tuser) begin
              closed_b <= 1'b1;
            end else begin
              closed_a <= 1'b1;
            end
          end
        end
        // Result counter for both passes
        if (cmd.prime) begin
          res_n <= '0;
        end else if (adv && !at_limit) begin
          res_n <= res_n + RES_CNT_W'(1);
        end
        if (st.count_done) begin
          counted <= 1'b1;
          if (at_limit) begin
            trunc <= 1'b1;
          end
        end
      end
    end
  end

  // Term stores: write on load, registered read at the next position
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (s_tuser) begin
        store_b[sel_cnt[IW-1:0]] <= '{coeff: in_coeff, expo: in_expo};
      end else begin
        store_a[sel_cnt[IW-1:0]] <= '{coeff: in_coeff, expo: in_expo};
      end
    end
    if (pos_a_next < CW'(MAX_TERMS)) begin
      rd_a <= store_a[pos_a_next[IW-1:0]];
    end
    if (pos_b_next < CW'(MAX_TERMS)) begin
      rd_b <= store_b[pos_b_next[IW-1:0]];
    end
  end

  // Output register: hold until taken, load on emit
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata[M_DATA_W-1:SUM_C_W+EXPO_W] <= '0;
      if (empty_run) begin
        m_tdata[SUM_C_W-1:0]               <= '0;
        m_tdata[SUM_C_W+EXPO_W-1:SUM_C_W]  <= '0;
      end else begin
        m_tdata[SUM_C_W-1:0]               <= step_coeff;
        m_tdata[SUM_C_W+EXPO_W-1:SUM_C_W]  <= step_expo;
      end
      m_tuser[0] <= empty_run;
      m_tuser[1] <= ovf || trunc;
      m_tlast    <= st.emit_last;
    end
  end

endmodule
